// ----- rtl/core/ecc_pkg.sv -----
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types, codes and constants for the electron candidate classifier.
// ----------------------------------------------------------------------------
package ecc_pkg;

    localparam int ECC_NUM_SECTORS = 6;
    localparam int ECC_COEF_WIDTH  = 24;

    localparam int ROW_LEN   = 8;
    localparam int FRAC_BITS = 22;
    localparam int INV_SHIFT = 28;
    localparam int ENERGY_W  = 16;
    localparam int DIV_W     = ENERGY_W + FRAC_BITS;
    localparam int INV_W     = INV_SHIFT + 1;

    localparam logic [11:0] NPHE_CUT_RST  = 12'd32;
    localparam logic [15:0] FL_MIN_E_RST  = 16'd246;
    localparam logic [7:0]  NSIGMA_RST    = 8'd80;

    localparam logic signed [2:0] ELECTRON_CHARGE = -3'sd1;

    localparam logic [1:0] CFG_NPHE_CUT   = 2'd0;
    localparam logic [1:0] CFG_FL_MIN_E   = 2'd1;
    localparam logic [1:0] CFG_NSIGMA_CUT = 2'd2;

    typedef enum logic [2:0] {
        RSN_PASS    = 3'd0,
        RSN_CHARGE  = 3'd1,
        RSN_SECTOR  = 3'd2,
        RSN_NPHE    = 3'd3,
        RSN_ENERGY  = 3'd4,
        RSN_SF      = 3'd5,
        RSN_LOADED  = 3'd6
    } reason_t;

    typedef struct packed {
        logic    valid;
        reason_t reason;
    } ctl_t;

    // Power-up coefficient for sector row k, slot n (mean a0..a3, sigma a0..a3),
    // Q.22 rounded half away from zero from units of 1e-5.
    function automatic logic signed [31:0] ecc_coef_reset(input int k, input int n);
        longint e5;
        longint mag;
        longint r;
        case (n)
            0:       e5 = 64'(23372 + 1000 * k);
            1, 5:    e5 = 64'd100000;
            2:       e5 = -64'(1726 + 500 * k);
            3:       e5 = 64'(50 + 10 * k);
            4:       e5 = 64'(1763 - 100 * k);
            default: e5 = 64'd0;
        endcase
        mag = (e5 < 0) ? -e5 : e5;
        r   = (mag * 64'd4194304 + 64'd50000) / 64'd100000;
        if (e5 < 0)
        begin
            r = -r;
        end
        return 32'(r);
    endfunction

endpackage

// ----- rtl/core/ecc_div.sv -----
// ----------------------------------------------------------------------------
// ecc_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ecc_div
    import ecc_pkg::*;
#(
    parameter int NUM_W = DIV_W,
    parameter int DEN_W = ENERGY_W
)
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];

    genvar i;
    generate
        for (i = 0; i < NUM_W; i++)
        begin : g_stage
            logic [DEN_W-1:0] rem_in;
            logic [NUM_W-1:0] num_in;
            logic [DEN_W-1:0] den_in;
            logic [NUM_W-1:0] quo_in;
            logic [DEN_W:0]   trial;
            logic             fits;

            if (i == 0)
            begin : g_first
                assign rem_in = '0;
                assign num_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i-1];
                assign num_in = num_reg[i-1];
                assign den_in = den_reg[i-1];
                assign quo_in = quo_reg[i-1];
            end

            assign trial = {rem_in, num_in[NUM_W-1]};
            assign fits  = (trial >= {1'b0, den_in});

            always_ff @(posedge clk)
            begin
                rem_reg[i] <= fits ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
                num_reg[i] <= {num_in[NUM_W-2:0], 1'b0};
                den_reg[i] <= den_in;
                quo_reg[i] <= {quo_in[NUM_W-2:0], fits};
            end
        end
    endgenerate

    assign quo = quo_reg[NUM_W-1];

endmodule

// ----- rtl/core/electron_candidate_classifier_core.sv -----
// ----------------------------------------------------------------------------
// electron_candidate_classifier_core
// Electron identification cuts with a per-sector sampling fraction check.
// ----------------------------------------------------------------------------
// Each item passes the entry register, the two 38-stage divider pipelines,
// six arithmetic stages and the output register before the done strobe.
// Throughput: one item per cycle; busy
// stays low.
// Reset: async active low; cut registers and coefficient table return to
// their power-up values. The receiver cannot stall.
module electron_candidate_classifier_core
    import ecc_pkg::*;
#(
    parameter int NUM_SECTORS = ECC_NUM_SECTORS,
    parameter int COEF_WIDTH  = ECC_COEF_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic signed [2:0]  charge,
    input  logic [2:0]         sector,
    input  logic [11:0]        nphe,
    input  logic [15:0]        energy_first_layer,
    input  logic [15:0]        energy_sum,
    input  logic [15:0]        momentum,
    input  logic [2:0]         coef_index,
    input  logic signed [23:0] coef_value,
    output logic               done,
    output logic               accepted,
    output logic [2:0]         reject_reason,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int SEC_W  = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
    localparam int PA2_W  = COEF_WIDTH + INV_W + 1;
    localparam int PA3_W  = COEF_WIDTH + 33;
    localparam int SUM_W  = COEF_WIDTH + 19;
    localparam int PRD_W  = COEF_WIDTH + 32;
    localparam int VAL_W  = PRD_W - FRAC_BITS;
    localparam int DIFF_W = ((VAL_W > DIV_W + 1) ? VAL_W : DIV_W + 1) + 1;
    localparam int DEV_W  = DIFF_W + 4;
    localparam int LIM_W  = VAL_W + 8;
    localparam int CMP_W  = (DEV_W > LIM_W) ? DEV_W : LIM_W;
    localparam logic [DIV_W-1:0] INV_NUM = DIV_W'(1) << INV_SHIFT;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    // ---------------- configuration ----------------
    logic [11:0] nphe_cut_reg;
    logic [15:0] fl_min_e_reg;
    logic [7:0]  nsigma_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nphe_cut_reg <= NPHE_CUT_RST;
            fl_min_e_reg <= FL_MIN_E_RST;
            nsigma_reg   <= NSIGMA_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NPHE_CUT:   nphe_cut_reg <= cfg_data[11:0];
                CFG_FL_MIN_E:   fl_min_e_reg <= cfg_data;
                CFG_NSIGMA_CUT: nsigma_reg   <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // ---------------- entry: cuts and table access ----------------
    logic             accept;
    logic             in_range;
    logic [SEC_W-1:0] row;
    reason_t          entry_reason;
    coef_t            load_val;

    coef_t bank_reg [ROW_LEN][NUM_SECTORS];

    assign accept   = start && !busy;
    assign in_range = (sector != 3'd0) && ({1'b0, sector} <= 4'(NUM_SECTORS));
    assign row      = in_range ? SEC_W'(sector - 3'd1) : '0;
    assign load_val = COEF_WIDTH'(32'(coef_value));

    always_comb
    begin
        if (!func)
        begin
            entry_reason = in_range ? RSN_LOADED : RSN_SECTOR;
        end
        else if (charge != ELECTRON_CHARGE)
        begin
            entry_reason = RSN_CHARGE;
        end
        else if (!in_range)
        begin
            entry_reason = RSN_SECTOR;
        end
        else if (nphe < nphe_cut_reg)
        begin
            entry_reason = RSN_NPHE;
        end
        else if (energy_first_layer < fl_min_e_reg)
        begin
            entry_reason = RSN_ENERGY;
        end
        else if (momentum == 16'd0 || energy_sum == 16'd0)
        begin
            entry_reason = RSN_SF;
        end
        else
        begin
            entry_reason = RSN_PASS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < ROW_LEN; n++)
            begin
                for (int s = 0; s < NUM_SECTORS; s++)
                begin
                    bank_reg[n][s] <= COEF_WIDTH'(ecc_coef_reset(s, n));
                end
            end
        end
        else if (accept && !func && in_range)
        begin
            bank_reg[coef_index][row] <= load_val;
        end
    end

    ctl_t        st1_ctl_reg;
    coef_t       st1_coef_reg [ROW_LEN];
    logic [15:0] st1_etot_reg;
    logic [15:0] st1_mom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_ctl_reg <= '{valid: 1'b0, reason: RSN_PASS};
        end
        else
        begin
            st1_ctl_reg <= '{valid: accept, reason: entry_reason};
        end
    end

    // read before this cycle's load; load items read the row too, but it goes unused
    always_ff @(posedge clk)
    begin
        for (int n = 0; n < ROW_LEN; n++)
        begin
            st1_coef_reg[n] <= bank_reg[n][row];
        end
        st1_etot_reg <= energy_sum;
        st1_mom_reg  <= momentum;
    end

    // ---------------- dividers and sideband ----------------
    logic [DIV_W-1:0] inv_quo;
    logic [DIV_W-1:0] sf_quo;

    ecc_div #(.NUM_W(DIV_W), .DEN_W(ENERGY_W)) u_div_inv
    (
        .clk (clk),
        .num (INV_NUM),
        .den (st1_etot_reg),
        .quo (inv_quo)
    );

    ecc_div #(.NUM_W(DIV_W), .DEN_W(ENERGY_W)) u_div_sf
    (
        .clk (clk),
        .num ({st1_etot_reg, {FRAC_BITS{1'b0}}}),
        .den (st1_mom_reg),
        .quo (sf_quo)
    );

    ctl_t  sb_ctl_reg  [DIV_W];
    coef_t sb_coef_reg [DIV_W][ROW_LEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_W; i++)
            begin
                sb_ctl_reg[i] <= '{valid: 1'b0, reason: RSN_PASS};
            end
        end
        else
        begin
            sb_ctl_reg[0] <= st1_ctl_reg;
            for (int i = 1; i < DIV_W; i++)
            begin
                sb_ctl_reg[i] <= sb_ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < ROW_LEN; n++)
        begin
            sb_coef_reg[0][n] <= st1_coef_reg[n];
            for (int i = 1; i < DIV_W; i++)
            begin
                sb_coef_reg[i][n] <= sb_coef_reg[i-1][n];
            end
        end
    end

    // ---------------- polynomial stages (index 0 mean, 1 sigma) ----------------
    logic [INV_W-1:0] inv;
    assign inv = inv_quo[INV_W-1:0];

    ctl_t p1_ctl_reg, p2_ctl_reg, p3_ctl_reg, p4_ctl_reg, p5_ctl_reg, p6_ctl_reg;

    logic [2*INV_W-1:0]       p1_sq_reg;
    logic signed [PA2_W-1:0]  p1_a2_reg [2];
    coef_t                    p1_a0_reg [2];
    coef_t                    p1_a1_reg [2];
    coef_t                    p1_a3_reg [2];
    logic [DIV_W-1:0]         p1_sf_reg;

    logic [31:0]              p2_inv2_reg;
    logic signed [SUM_W-1:0]  p2_s_reg  [2];
    coef_t                    p2_a0_reg [2];
    coef_t                    p2_a3_reg [2];
    logic [DIV_W-1:0]         p2_sf_reg;

    logic signed [PA3_W-1:0]  p3_a3_reg [2];
    logic signed [SUM_W-1:0]  p3_s_reg  [2];
    coef_t                    p3_a0_reg [2];
    logic [DIV_W-1:0]         p3_sf_reg;

    logic signed [31:0]       p4_inner_reg [2];
    coef_t                    p4_a0_reg    [2];
    logic [DIV_W-1:0]         p4_sf_reg;

    logic signed [PRD_W-1:0]  p5_prod_reg [2];
    logic [DIV_W-1:0]         p5_sf_reg;

    logic [CMP_W-1:0]         p6_dev_reg;
    logic [CMP_W-1:0]         p6_lim_reg;
    logic                     p6_signz_reg;

    logic [2*INV_W-1:0]       sq_next;
    logic [31:0]              inv2_next;
    logic signed [SUM_W-1:0]  sum_next   [2];
    logic signed [31:0]       inner_next [2];
    logic signed [VAL_W-1:0]  mean_next;
    logic signed [VAL_W-1:0]  sigma_next;
    logic signed [DIFF_W-1:0] diff_next;
    logic [DIFF_W-1:0]        adiff_next;
    logic [VAL_W-1:0]         asigma_next;

    assign sq_next = (2*INV_W)'(inv) * (2*INV_W)'(inv);

    always_comb
    begin
        if (p1_sq_reg[2*INV_W-1:48] != '0)
        begin
            inv2_next = 32'hFFFF_FFFF;
        end
        else
        begin
            inv2_next = p1_sq_reg[47:16];
        end
    end

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            sum_next[j] = p3_s_reg[j] + SUM_W'(p3_a3_reg[j] >>> 16);
            if (sum_next[j][SUM_W-1:31] == '0 || sum_next[j][SUM_W-1:31] == '1)
            begin
                inner_next[j] = sum_next[j][31:0];
            end
            else if (sum_next[j][SUM_W-1])
            begin
                inner_next[j] = 32'sh8000_0000;
            end
            else
            begin
                inner_next[j] = 32'sh7FFF_FFFF;
            end
        end
    end

    always_comb
    begin
        mean_next   = VAL_W'(p5_prod_reg[0] >>> FRAC_BITS);
        sigma_next  = VAL_W'(p5_prod_reg[1] >>> FRAC_BITS);
        diff_next   = $signed(DIFF_W'({1'b0, p5_sf_reg})) - DIFF_W'(mean_next);
        adiff_next  = diff_next[DIFF_W-1] ? DIFF_W'(-diff_next) : DIFF_W'(diff_next);
        asigma_next = sigma_next[VAL_W-1] ? VAL_W'(-sigma_next) : VAL_W'(sigma_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctl_reg <= '{valid: 1'b0, reason: RSN_PASS};
            p2_ctl_reg <= '{valid: 1'b0, reason: RSN_PASS};
            p3_ctl_reg <= '{valid: 1'b0, reason: RSN_PASS};
            p4_ctl_reg <= '{valid: 1'b0, reason: RSN_PASS};
            p5_ctl_reg <= '{valid: 1'b0, reason: RSN_PASS};
            p6_ctl_reg <= '{valid: 1'b0, reason: RSN_PASS};
        end
        else
        begin
            p1_ctl_reg <= sb_ctl_reg[DIV_W-1];
            p2_ctl_reg <= p1_ctl_reg;
            p3_ctl_reg <= p2_ctl_reg;
            p4_ctl_reg <= p3_ctl_reg;
            p5_ctl_reg <= p4_ctl_reg;
            p6_ctl_reg <= p5_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_sq_reg   <= sq_next;
        p1_sf_reg   <= sf_quo;
        p2_inv2_reg <= inv2_next;
        p2_sf_reg   <= p1_sf_reg;
        p3_sf_reg   <= p2_sf_reg;
        p4_sf_reg   <= p3_sf_reg;
        p5_sf_reg   <= p4_sf_reg;
        for (int j = 0; j < 2; j++)
        begin
            p1_a2_reg[j] <= PA2_W'(sb_coef_reg[DIV_W-1][4*j+2])
                          * PA2_W'($signed({1'b0, inv}));
            p1_a0_reg[j] <= sb_coef_reg[DIV_W-1][4*j];
            p1_a1_reg[j] <= sb_coef_reg[DIV_W-1][4*j+1];
            p1_a3_reg[j] <= sb_coef_reg[DIV_W-1][4*j+3];

            p2_s_reg[j]  <= SUM_W'(p1_a1_reg[j]) + SUM_W'(p1_a2_reg[j] >>> 16);
            p2_a0_reg[j] <= p1_a0_reg[j];
            p2_a3_reg[j] <= p1_a3_reg[j];

            p3_a3_reg[j] <= PA3_W'(p2_a3_reg[j]) * PA3_W'($signed({1'b0, p2_inv2_reg}));
            p3_s_reg[j]  <= p2_s_reg[j];
            p3_a0_reg[j] <= p2_a0_reg[j];

            p4_inner_reg[j] <= inner_next[j];
            p4_a0_reg[j]    <= p3_a0_reg[j];

            p5_prod_reg[j] <= PRD_W'(p4_a0_reg[j]) * PRD_W'(p4_inner_reg[j]);
        end
        p6_dev_reg   <= CMP_W'({adiff_next, 4'b0000});
        p6_lim_reg   <= CMP_W'(asigma_next) * CMP_W'(nsigma_reg);
        p6_signz_reg <= (sigma_next != '0);
    end

    // ---------------- result ----------------
    reason_t final_reason;

    always_comb
    begin
        if (p6_ctl_reg.reason != RSN_PASS)
        begin
            final_reason = p6_ctl_reg.reason;
        end
        else if (p6_signz_reg && (p6_dev_reg > p6_lim_reg))
        begin
            final_reason = RSN_SF;
        end
        else
        begin
            final_reason = RSN_PASS;
        end
    end

    logic    done_reg;
    reason_t reason_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= p6_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        reason_reg <= final_reason;
    end

    assign done          = done_reg;
    assign reject_reason = reason_reg;
    assign accepted      = (reason_reg == RSN_PASS);

endmodule

// ----- sim/electron_candidate_classifier_core_tb.sv -----
// ----------------------------------------------------------------------------
// electron_candidate_classifier_core_tb
// Self-checking bench: a directed table of edge cases followed by random
// particle streams and coefficient loads, checked against a bit-exact
// predictor across several cut settings.
// ----------------------------------------------------------------------------
module electron_candidate_classifier_core_tb
    import ecc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NSEC      = ECC_NUM_SECTORS;
    localparam int          TBL_DEPTH = NSEC * ROW_LEN;
    localparam int          SETTLE    = 60;
    localparam int          WD_LIMIT  = 4000;
    localparam logic [1:0]  CFG_SPARE = 2'd3;
    localparam logic        FN_LOAD   = 1'b0;
    localparam logic        FN_CLASS  = 1'b1;

    typedef struct {
        logic              func;
        logic signed [2:0] charge;
        logic [2:0]        sector;
        logic [11:0]       nphe;
        logic [15:0]       efl;
        logic [15:0]       etot;
        logic [15:0]       mom;
        logic [2:0]        cidx;
        logic signed [23:0] cval;
        bit                typed;
        reason_t           rsn;
    } particle_row_t;

    typedef struct {
        logic    acc;
        reason_t rsn;
    } verdict_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               func = 1'b0;
    logic signed [2:0]  charge = '0;
    logic [2:0]         sector = '0;
    logic [11:0]        nphe = '0;
    logic [15:0]        energy_first_layer = '0;
    logic [15:0]        energy_sum = '0;
    logic [15:0]        momentum = '0;
    logic [2:0]         coef_index = '0;
    logic signed [23:0] coef_value = '0;
    logic               done;
    logic               accepted;
    logic [2:0]         reject_reason;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    // predictor state
    logic signed [23:0] coef_mem [TBL_DEPTH];
    logic [11:0]        nphe_min;
    logic [15:0]        efl_min;
    logic [7:0]         nsigma;

    verdict_t           pending_verdicts [$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    bit                 allow_gaps = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    electron_candidate_classifier_core DUT (.*);

    function automatic logic signed [23:0] e5_to_q22(input longint e5);
        longint mag;
        longint r;
        mag = (e5 < 0) ? -e5 : e5;
        r   = (mag * 64'd4194304 + 64'd50000) / 64'd100000;
        return 24'((e5 < 0) ? -r : r);
    endfunction

    function automatic void load_power_up_table();
        for (int k = 0; k < NSEC; k++)
        begin
            coef_mem[k*ROW_LEN + 0] = e5_to_q22(23372 + 1000 * k);
            coef_mem[k*ROW_LEN + 1] = e5_to_q22(100000);
            coef_mem[k*ROW_LEN + 2] = e5_to_q22(-(1726 + 500 * k));
            coef_mem[k*ROW_LEN + 3] = e5_to_q22(50 + 10 * k);
            coef_mem[k*ROW_LEN + 4] = e5_to_q22(1763 - 100 * k);
            coef_mem[k*ROW_LEN + 5] = e5_to_q22(100000);
            coef_mem[k*ROW_LEN + 6] = '0;
            coef_mem[k*ROW_LEN + 7] = '0;
        end
        nphe_min = NPHE_CUT_RST;
        efl_min  = FL_MIN_E_RST;
        nsigma   = NSIGMA_RST;
    endfunction

    // a0 * (a1 + a2/E + a3/E^2) in Q.22
    function automatic longint sector_curve(input int base, input longint inv,
                                            input longint inv2);
        longint a0, a1, a2, a3, inner;
        a0 = coef_mem[base];
        a1 = coef_mem[base + 1];
        a2 = coef_mem[base + 2];
        a3 = coef_mem[base + 3];
        inner = a1 + ((a2 * inv) >>> 16) + ((a3 * inv2) >>> 16);
        if (inner > 64'sd2147483647)
            inner = 64'sd2147483647;
        if (inner < -64'sd2147483648)
            inner = -64'sd2147483648;
        return (a0 * inner) >>> FRAC_BITS;
    endfunction

    function automatic reason_t classify_particle(input particle_row_t p);
        longint      inv, inv2, mean, sigma, sf, dev, lim;
        logic [63:0] sq;
        int          base;
        if (p.func == FN_LOAD)
        begin
            if (p.sector < 1 || p.sector > NSEC)
                return RSN_SECTOR;
            coef_mem[(p.sector - 1) * ROW_LEN + p.cidx] = p.cval;
            return RSN_LOADED;
        end
        if (p.charge != ELECTRON_CHARGE)
            return RSN_CHARGE;
        if (p.sector < 1 || p.sector > NSEC)
            return RSN_SECTOR;
        if (p.nphe < nphe_min)
            return RSN_NPHE;
        if (p.efl < efl_min)
            return RSN_ENERGY;
        if (p.mom == 0 || p.etot == 0)
            return RSN_SF;
        base  = (p.sector - 1) * ROW_LEN;
        inv   = (64'sd1 <<< INV_SHIFT) / longint'(p.etot);
        sq    = (64'(inv) * 64'(inv)) >> 16;
        inv2  = (sq > 64'hFFFF_FFFF) ? 64'sh FFFF_FFFF : longint'(sq);
        mean  = sector_curve(base, inv, inv2);
        sigma = sector_curve(base + 4, inv, inv2);
        sf    = (longint'(p.etot) <<< FRAC_BITS) / longint'(p.mom);
        if (sigma == 0)
            return RSN_PASS;
        dev = 16 * ((sf > mean) ? sf - mean : mean - sf);
        lim = longint'(nsigma) * ((sigma < 0) ? -sigma : sigma);
        return (dev > lim) ? RSN_SF : RSN_PASS;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("unexpected result, reason", reject_reason, -1);
            else
            begin
                v = pending_verdicts.pop_front();
                if (accepted !== v.acc)
                    report_mismatch("accepted", accepted, v.acc);
                if (reject_reason !== v.rsn)
                    report_mismatch("reject_reason", reject_reason, v.rsn);
            end
        end
    end

    // watchdog: cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_particle(input particle_row_t p);
        verdict_t v;
        start              <= 1'b1;
        func               <= p.func;
        charge             <= p.charge;
        sector             <= p.sector;
        nphe               <= p.nphe;
        energy_first_layer <= p.efl;
        energy_sum         <= p.etot;
        momentum           <= p.mom;
        coef_index         <= p.cidx;
        coef_value         <= p.cval;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        v.rsn = classify_particle(p);
        if (p.typed)
            v.rsn = p.rsn;
        v.acc = (v.rsn == RSN_PASS);
        pending_verdicts.insert(pending_verdicts.size(), v);
        // hold start high unless a gap follows
        if (allow_gaps && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19))
                @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic write_cut(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NPHE_CUT:   nphe_min = data[11:0];
            CFG_FL_MIN_E:   efl_min  = data;
            CFG_NSIGMA_CUT: nsigma   = data[7:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    function automatic particle_row_t random_particle();
        particle_row_t p;
        int            pick;
        pick     = $urandom_range(0, 99);
        p.typed  = 1'b0;
        p.rsn    = RSN_PASS;
        p.func   = FN_CLASS;
        p.charge = ELECTRON_CHARGE;
        p.sector = 3'($urandom_range(1, NSEC));
        p.nphe   = 12'($urandom_range(nphe_min, 4095));
        p.efl    = 16'($urandom_range(efl_min, 65535));
        p.mom    = 16'($urandom_range(1, 65535));
        p.etot   = 16'((longint'(p.mom) * $urandom_range(150, 350)) / 1000);
        if (p.etot == 0)
            p.etot = 16'd1;
        p.cidx   = 3'($urandom);
        p.cval   = 24'($urandom);
        if (pick < 15)
            p.etot = 16'($urandom);
        else if (pick < 19)
        begin
            p.func = FN_LOAD;
            // half of the loads use plausible values so the table stays useful
            if ($urandom_range(0, 1))
                p.cval = 24'(coef_mem[(p.sector - 1) * ROW_LEN + p.cidx]
                              + $signed(24'($urandom_range(0, 8191)) - 24'sd4096));
        end
        else if (pick < 32)
        begin
            p.func   = 1'($urandom);
            p.charge = 3'($urandom);
            p.sector = 3'($urandom);
            p.nphe   = 12'($urandom);
            p.efl    = 16'($urandom);
            p.etot   = 16'($urandom);
            p.mom    = 16'($urandom);
        end
        return p;
    endfunction

    particle_row_t edge_rows [22] = '{
        '{FN_CLASS,  3'sd0, 3'd1, 12'd4095, 16'hFFFF, 16'd2048, 16'd8192, 3'd0, 24'sd0, 1, RSN_CHARGE},
        '{FN_CLASS,  3'sd3, 3'd1, 12'd4095, 16'hFFFF, 16'd2048, 16'd8192, 3'd0, 24'sd0, 1, RSN_CHARGE},
        '{FN_CLASS, -3'sd4, 3'd1, 12'd4095, 16'hFFFF, 16'd2048, 16'd8192, 3'd0, 24'sd0, 1, RSN_CHARGE},
        '{FN_CLASS, -3'sd1, 3'd0, 12'd4095, 16'hFFFF, 16'd2048, 16'd8192, 3'd0, 24'sd0, 1, RSN_SECTOR},
        '{FN_CLASS, -3'sd1, 3'd7, 12'd4095, 16'hFFFF, 16'd2048, 16'd8192, 3'd0, 24'sd0, 1, RSN_SECTOR},
        '{FN_CLASS, -3'sd1, 3'd1, 12'd0,    16'hFFFF, 16'd2048, 16'd8192, 3'd0, 24'sd0, 1, RSN_NPHE},
        '{FN_CLASS, -3'sd1, 3'd1, 12'd31,   16'hFFFF, 16'd2048, 16'd8192, 3'd0, 24'sd0, 1, RSN_NPHE},
        '{FN_CLASS, -3'sd1, 3'd1, 12'd32,   16'd0,    16'd2048, 16'd8192, 3'd0, 24'sd0, 1, RSN_ENERGY},
        '{FN_CLASS, -3'sd1, 3'd1, 12'd32,   16'd245,  16'd2048, 16'd8192, 3'd0, 24'sd0, 1, RSN_ENERGY},
        '{FN_CLASS, -3'sd1, 3'd2, 12'd4095, 16'd246,  16'd2048, 16'd0,    3'd0, 24'sd0, 1, RSN_SF},
        '{FN_CLASS, -3'sd1, 3'd2, 12'd4095, 16'd246,  16'd0,    16'd8192, 3'd0, 24'sd0, 1, RSN_SF},
        '{FN_CLASS, -3'sd1, 3'd1, 12'd4095, 16'hFFFF, 16'd2048, 16'd8192, 3'd0, 24'sd0, 0, RSN_PASS},
        '{FN_CLASS, -3'sd1, 3'd6, 12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd0, 24'sd0, 0, RSN_PASS},
        '{FN_CLASS, -3'sd1, 3'd3, 12'd4095, 16'hFFFF, 16'hFFFF, 16'd1,    3'd0, 24'sd0, 0, RSN_PASS},
        '{FN_CLASS, -3'sd1, 3'd4, 12'd4095, 16'hFFFF, 16'd1,    16'hFFFF, 3'd0, 24'sd0, 0, RSN_PASS},
        '{FN_LOAD,   3'sd0, 3'd0, 12'd0,    16'd0,    16'd0,    16'd0,    3'd4, 24'sd5, 1, RSN_SECTOR},
        '{FN_LOAD,   3'sd0, 3'd7, 12'd0,    16'd0,    16'd0,    16'd0,    3'd4, 24'sd5, 1, RSN_SECTOR},
        '{FN_LOAD,   3'sd0, 3'd6, 12'd0,    16'd0,    16'd0,    16'd0,    3'd4, 24'sd0, 1, RSN_LOADED},
        '{FN_CLASS, -3'sd1, 3'd6, 12'd4095, 16'hFFFF, 16'hFFFF, 16'd1,    3'd0, 24'sd0, 0, RSN_PASS},
        '{FN_LOAD,   3'sd0, 3'd2, 12'd0,    16'd0,    16'd0,    16'd0,    3'd7, -24'sd8388608, 1, RSN_LOADED},
        '{FN_LOAD,   3'sd0, 3'd3, 12'd0,    16'd0,    16'd0,    16'd0,    3'd0, 24'sd8388607,  1, RSN_LOADED},
        '{FN_CLASS, -3'sd1, 3'd2, 12'd4095, 16'hFFFF, 16'd1000, 16'd4096, 3'd0, 24'sd0, 0, RSN_PASS}
    };

    initial
    begin
        logic [15:0] cut_sets [5][3];
        load_power_up_table();
        cut_sets = '{
            '{16'd0,    16'd0,    16'd0},
            '{16'd4095, 16'hFFFF, 16'd255},
            '{16'($urandom_range(0, 400)), 16'($urandom_range(0, 2000)), 16'($urandom)},
            '{16'($urandom), 16'($urandom), 16'($urandom_range(0, 255))},
            '{16'(NPHE_CUT_RST), 16'(FL_MIN_E_RST), 16'(NSIGMA_RST)}
        };
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edge_rows[i])
            send_particle(edge_rows[i]);

        for (int ph = 0; ph < 5; ph++)
        begin
            drain_results();
            write_cut(CFG_NPHE_CUT,   cut_sets[ph][0]);
            write_cut(CFG_FL_MIN_E,   cut_sets[ph][1]);
            write_cut(CFG_NSIGMA_CUT, cut_sets[ph][2]);
            if (ph == 2)
                write_cut(CFG_SPARE, 16'($urandom));
            allow_gaps = (ph < 4);
            repeat (350)
                send_particle(random_particle());
        end

        drain_results();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
